### hw/rtl/framebuffer_raster_op_engine_macros.svh
// Assertion macros for the framebuffer raster-op engine.
// Used by RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef FRAMEBUFFER_RASTER_OP_ENGINE_MACROS_SVH
`define FRAMEBUFFER_RASTER_OP_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FROE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FROE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FROE_ASSERT(lbl, prop, msg)
`define FROE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/fbrop_pkg.sv
// Shared constants, request codes and types of the framebuffer raster-op engine.
// No dependencies.
`default_nettype none
package fbrop_pkg;
    localparam int CW = 7;
    localparam int VW = 20;
    localparam int PIX_W = 24;
    localparam int GLYPH_COUNT = 128;
    localparam int GLYPH_ROWS = 16;
    localparam int GLYPH_COLS = 8;
    localparam int GLYPH_AW = $clog2(GLYPH_COUNT * GLYPH_ROWS);
    localparam int DEF_MAX_WIDTH = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam logic [2:0] REQ_WRITE  = 3'd0;
    localparam logic [2:0] REQ_READ   = 3'd1;
    localparam logic [2:0] REQ_FILL   = 3'd2;
    localparam logic [2:0] REQ_INVERT = 3'd3;
    localparam logic [2:0] REQ_BLIT   = 3'd4;
    localparam logic [2:0] REQ_GLOAD  = 3'd5;
    localparam logic [2:0] REQ_CHAR   = 3'd6;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_HEIGHT = 2'd2;

    typedef struct packed {
        logic          enable;
        logic [CW-1:0] aw;
        logic [CW-1:0] ah;
    } cfg_t;
endpackage
`default_nettype wire

### hw/rtl/fbrop_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module fbrop_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

### hw/rtl/fbrop_seq.sv
// Request sequencer: clipping steps, pixel walker and both stores.
// Depends on fbrop_pkg, fbrop_ram and the assertion macro header.
`default_nettype none
`include "framebuffer_raster_op_engine_macros.svh"
module fbrop_seq #(
    parameter int MAX_WIDTH = fbrop_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fbrop_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire fbrop_pkg::cfg_t   cfg,
    input  wire logic              start,
    input  wire logic [2:0]        req_type,
    input  wire logic [15:0]       x,
    input  wire logic [15:0]       y,
    input  wire logic [15:0]       width,
    input  wire logic [15:0]       height,
    input  wire logic [15:0]       src_x,
    input  wire logic [15:0]       src_y,
    input  wire logic [31:0]       color,
    input  wire logic [31:0]       background,
    input  wire logic [7:0]        char_code,
    input  wire logic [3:0]        glyph_row,
    input  wire logic [7:0]        glyph_bits,
    input  wire logic              slot_free,
    output logic                   ready,
    output logic                   done,
    output logic [23:0]            res_data,
    output logic                   res_status
);
    localparam int CW = fbrop_pkg::CW;
    localparam int VW = fbrop_pkg::VW;
    localparam int GAW = fbrop_pkg::GLYPH_AW;
    localparam int FR_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int GL_DEPTH = fbrop_pkg::GLYPH_COUNT * fbrop_pkg::GLYPH_ROWS;
    localparam int AW = $clog2(FR_DEPTH);
    localparam int CLR_N = (FR_DEPTH > GL_DEPTH) ? FR_DEPTH : GL_DEPTH;
    localparam int CLRW = $clog2(CLR_N);
    localparam int CMAX = (1 << CW) - 1;
    localparam int WLIM = (MAX_WIDTH > CMAX) ? CMAX : MAX_WIDTH;
    localparam int HLIM = (MAX_HEIGHT > CMAX) ? CMAX : MAX_HEIGHT;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DECODE = 4'd2;
    localparam logic [3:0] S_RECT2  = 4'd3;
    localparam logic [3:0] S_BLIT1  = 4'd4;
    localparam logic [3:0] S_BLIT2  = 4'd5;
    localparam logic [3:0] S_BLIT3  = 4'd6;
    localparam logic [3:0] S_BLIT4  = 4'd7;
    localparam logic [3:0] S_SETUP  = 4'd8;
    localparam logic [3:0] S_RD     = 4'd9;
    localparam logic [3:0] S_WR     = 4'd10;
    localparam logic [3:0] S_PIXRD  = 4'd11;
    localparam logic [3:0] S_GROW   = 4'd12;
    localparam logic [3:0] S_GCOL   = 4'd13;
    localparam logic [3:0] S_DONE   = 4'd14;

    localparam logic [CW-1:0] GCOL_LAST = CW'(fbrop_pkg::GLYPH_COLS - 1);
    localparam logic [CW-1:0] GROW_LAST = CW'(fbrop_pkg::GLYPH_ROWS - 1);

    function automatic logic [AW-1:0] pix_addr(input logic [CW-1:0] px,
                                               input logic [CW-1:0] py);
        pix_addr = AW'(py) * AW'(MAX_WIDTH) + AW'(px);
    endfunction

    logic [3:0]           state_reg, state_next;
    logic [CLRW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [2:0]           req_reg, req_next;
    logic signed [VW-1:0] vx_reg, vx_next, vy_reg, vy_next;
    logic signed [VW-1:0] vcx_reg, vcx_next, vcy_reg, vcy_next;
    logic signed [VW-1:0] vsx_reg, vsx_next, vsy_reg, vsy_next;
    logic [23:0]          color_reg, color_next, bg_reg, bg_next;
    logic                 bg_transp_reg, bg_transp_next;
    logic [7:0]           code_reg, code_next, gbits_reg, gbits_next;
    logic [3:0]           grow_reg, grow_next;
    logic [CW-1:0]        cur_dx_reg, cur_dx_next, cur_dy_reg, cur_dy_next;
    logic [CW-1:0]        cur_sx_reg, cur_sx_next, cur_sy_reg, cur_sy_next;
    logic [CW-1:0]        dx_start_reg, dx_start_next, sx_start_reg, sx_start_next;
    logic [CW-1:0]        cc_reg, cc_next, rr_reg, rr_next;
    logic [CW-1:0]        cx_last_reg, cx_last_next, cy_last_reg, cy_last_next;
    logic                 col_rev_reg, col_rev_next, row_rev_reg, row_rev_next;
    logic                 any_reg, any_next;
    logic [23:0]          data_reg, data_next;
    logic                 status_reg, status_next;

    logic [CW-1:0]        cw, ch;
    logic signed [VW-1:0] cw_s, ch_s;
    logic signed [VW-1:0] xe, ye, x0, y0, x1, y1, px, py, t_dx, t_sx, t_dy, t_sy;
    logic                 in_xy, in_p, gbit, wrote;

    logic                 fr_we, fr_re, gl_we, gl_re;
    logic [AW-1:0]        fr_waddr, fr_raddr;
    logic [23:0]          fr_wdata, fr_rdata;
    logic [GAW-1:0]       gl_waddr, gl_raddr;
    logic [7:0]           gl_wdata, gl_rdata;
    logic [6:0]           gidx;

    assign cw = (cfg.aw > CW'(WLIM)) ? CW'(WLIM) : cfg.aw;
    assign ch = (cfg.ah > CW'(HLIM)) ? CW'(HLIM) : cfg.ah;
    assign cw_s = signed'({{(VW - CW){1'b0}}, cw});
    assign ch_s = signed'({{(VW - CW){1'b0}}, ch});

    assign xe = vx_reg + vcx_reg;
    assign ye = vy_reg + vcy_reg;
    assign x0 = (vx_reg < 0) ? VW'(0) : vx_reg;
    assign y0 = (vy_reg < 0) ? VW'(0) : vy_reg;
    assign x1 = (xe > cw_s) ? cw_s : xe;
    assign y1 = (ye > ch_s) ? ch_s : ye;
    assign in_xy = (vx_reg >= 0) && (vx_reg < cw_s) && (vy_reg >= 0) && (vy_reg < ch_s);
    assign px = vx_reg + signed'({{(VW - CW){1'b0}}, cc_reg});
    assign py = vy_reg + signed'({{(VW - CW){1'b0}}, rr_reg});
    assign in_p = (px >= 0) && (px < cw_s) && (py >= 0) && (py < ch_s);
    assign gbit = gl_rdata[~cc_reg[2:0]];
    assign wrote = in_p && (gbit || !bg_transp_reg);
    assign gidx = code_reg[7] ? 7'd0 : code_reg[6:0];
    assign t_dx = vx_reg + vcx_reg - VW'(1);
    assign t_sx = vsx_reg + vcx_reg - VW'(1);
    assign t_dy = vy_reg + vcy_reg - VW'(1);
    assign t_sy = vsy_reg + vcy_reg - VW'(1);

    assign ready = (state_reg == S_IDLE);
    assign res_data = data_reg;
    assign res_status = status_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_cnt_next = clr_cnt_reg;
        req_next = req_reg;
        vx_next = vx_reg;
        vy_next = vy_reg;
        vcx_next = vcx_reg;
        vcy_next = vcy_reg;
        vsx_next = vsx_reg;
        vsy_next = vsy_reg;
        color_next = color_reg;
        bg_next = bg_reg;
        bg_transp_next = bg_transp_reg;
        code_next = code_reg;
        gbits_next = gbits_reg;
        grow_next = grow_reg;
        cur_dx_next = cur_dx_reg;
        cur_dy_next = cur_dy_reg;
        cur_sx_next = cur_sx_reg;
        cur_sy_next = cur_sy_reg;
        dx_start_next = dx_start_reg;
        sx_start_next = sx_start_reg;
        cc_next = cc_reg;
        rr_next = rr_reg;
        cx_last_next = cx_last_reg;
        cy_last_next = cy_last_reg;
        col_rev_next = col_rev_reg;
        row_rev_next = row_rev_reg;
        any_next = any_reg;
        data_next = data_reg;
        status_next = status_reg;
        done = 1'b0;
        fr_we = 1'b0;
        fr_re = 1'b0;
        gl_we = 1'b0;
        gl_re = 1'b0;
        fr_waddr = pix_addr(cur_dx_reg, cur_dy_reg);
        fr_raddr = pix_addr(cur_dx_reg, cur_dy_reg);
        fr_wdata = color_reg;
        gl_waddr = {code_reg[6:0], grow_reg};
        gl_raddr = {gidx, rr_reg[3:0]};
        gl_wdata = gbits_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                fr_we = ({1'b0, clr_cnt_reg} < (CLRW + 1)'(FR_DEPTH));
                fr_waddr = clr_cnt_reg[AW-1:0];
                fr_wdata = '0;
                gl_we = ({1'b0, clr_cnt_reg} < (CLRW + 1)'(GL_DEPTH));
                gl_waddr = clr_cnt_reg[GAW-1:0];
                gl_wdata = '0;
                clr_cnt_next = clr_cnt_reg + CLRW'(1);
                if (clr_cnt_reg == CLRW'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req_type;
                    vx_next = signed'({{(VW - 16){x[15]}}, x});
                    vy_next = signed'({{(VW - 16){y[15]}}, y});
                    vcx_next = signed'({{(VW - 16){width[15]}}, width});
                    vcy_next = signed'({{(VW - 16){height[15]}}, height});
                    vsx_next = signed'({{(VW - 16){src_x[15]}}, src_x});
                    vsy_next = signed'({{(VW - 16){src_y[15]}}, src_y});
                    color_next = color[23:0];
                    bg_next = background[23:0];
                    bg_transp_next = |background[31:24];
                    code_next = char_code;
                    grow_next = glyph_row;
                    gbits_next = glyph_bits;
                    data_next = '0;
                    status_next = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                if (cfg.enable)
                begin
                    unique case (req_reg)
                        fbrop_pkg::REQ_WRITE:
                        begin
                            if (in_xy)
                            begin
                                vcx_next = VW'(1);
                                vcy_next = VW'(1);
                                vsx_next = vx_reg;
                                vsy_next = vy_reg;
                                state_next = S_SETUP;
                            end
                        end
                        fbrop_pkg::REQ_READ:
                        begin
                            if (in_xy)
                            begin
                                fr_re = 1'b1;
                                fr_raddr = pix_addr(vx_reg[CW-1:0], vy_reg[CW-1:0]);
                                state_next = S_PIXRD;
                            end
                        end
                        fbrop_pkg::REQ_FILL, fbrop_pkg::REQ_INVERT:
                        begin
                            if (vcx_reg > 0 && vcy_reg > 0 && x0 < x1 && y0 < y1)
                            begin
                                vx_next = x0;
                                vy_next = y0;
                                vcx_next = x1;
                                vcy_next = y1;
                                vsx_next = x0;
                                vsy_next = y0;
                                state_next = S_RECT2;
                            end
                        end
                        fbrop_pkg::REQ_BLIT:
                        begin
                            state_next = S_BLIT1;
                        end
                        fbrop_pkg::REQ_GLOAD:
                        begin
                            if (!code_reg[7])
                            begin
                                gl_we = 1'b1;
                                status_next = 1'b0;
                            end
                        end
                        fbrop_pkg::REQ_CHAR:
                        begin
                            rr_next = '0;
                            any_next = 1'b0;
                            state_next = S_GROW;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_RECT2:
            begin
                vcx_next = vcx_reg - vx_reg;
                vcy_next = vcy_reg - vy_reg;
                state_next = S_SETUP;
            end
            S_BLIT1:
            begin
                if (vcx_reg <= 0 || vcy_reg <= 0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    if (vx_reg < 0)
                    begin
                        vsx_next = vsx_reg - vx_reg;
                        vcx_next = vcx_reg + vx_reg;
                        vx_next = '0;
                    end
                    if (vy_reg < 0)
                    begin
                        vsy_next = vsy_reg - vy_reg;
                        vcy_next = vcy_reg + vy_reg;
                        vy_next = '0;
                    end
                    state_next = S_BLIT2;
                end
            end
            S_BLIT2:
            begin
                if (vsx_reg < 0)
                begin
                    vx_next = vx_reg - vsx_reg;
                    vcx_next = vcx_reg + vsx_reg;
                    vsx_next = '0;
                end
                if (vsy_reg < 0)
                begin
                    vy_next = vy_reg - vsy_reg;
                    vcy_next = vcy_reg + vsy_reg;
                    vsy_next = '0;
                end
                state_next = S_BLIT3;
            end
            S_BLIT3:
            begin
                if (vcx_reg <= 0 || vcy_reg <= 0 || vx_reg >= cw_s || vy_reg >= ch_s
                    || vsx_reg >= cw_s || vsy_reg >= ch_s)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    if (xe > cw_s)
                    begin
                        vcx_next = cw_s - vx_reg;
                    end
                    if (ye > ch_s)
                    begin
                        vcy_next = ch_s - vy_reg;
                    end
                    state_next = S_BLIT4;
                end
            end
            S_BLIT4:
            begin
                if (vsx_reg + vcx_reg > cw_s)
                begin
                    vcx_next = cw_s - vsx_reg;
                end
                if (vsy_reg + vcy_reg > ch_s)
                begin
                    vcy_next = ch_s - vsy_reg;
                end
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                row_rev_next = (req_reg == fbrop_pkg::REQ_BLIT) && (vy_reg > vsy_reg);
                col_rev_next = (req_reg == fbrop_pkg::REQ_BLIT) && (vy_reg == vsy_reg)
                               && !(vx_reg < vsx_reg);
                dx_start_next = col_rev_next ? t_dx[CW-1:0] : vx_reg[CW-1:0];
                sx_start_next = col_rev_next ? t_sx[CW-1:0] : vsx_reg[CW-1:0];
                cur_dx_next = dx_start_next;
                cur_sx_next = sx_start_next;
                cur_dy_next = row_rev_next ? t_dy[CW-1:0] : vy_reg[CW-1:0];
                cur_sy_next = row_rev_next ? t_sy[CW-1:0] : vsy_reg[CW-1:0];
                cx_last_next = CW'(vcx_reg - VW'(1));
                cy_last_next = CW'(vcy_reg - VW'(1));
                cc_next = '0;
                rr_next = '0;
                status_next = 1'b0;
                if (req_reg == fbrop_pkg::REQ_WRITE || req_reg == fbrop_pkg::REQ_FILL)
                begin
                    state_next = S_WR;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                fr_re = 1'b1;
                if (req_reg == fbrop_pkg::REQ_BLIT)
                begin
                    fr_raddr = pix_addr(cur_sx_reg, cur_sy_reg);
                end
                state_next = S_WR;
            end
            S_WR:
            begin
                fr_we = 1'b1;
                if (req_reg == fbrop_pkg::REQ_INVERT)
                begin
                    fr_wdata = ~fr_rdata;
                end
                else if (req_reg == fbrop_pkg::REQ_BLIT)
                begin
                    fr_wdata = fr_rdata;
                end
                if (cc_reg == cx_last_reg)
                begin
                    cc_next = '0;
                    cur_dx_next = dx_start_reg;
                    cur_sx_next = sx_start_reg;
                    rr_next = rr_reg + CW'(1);
                    cur_dy_next = row_rev_reg ? cur_dy_reg - CW'(1) : cur_dy_reg + CW'(1);
                    cur_sy_next = row_rev_reg ? cur_sy_reg - CW'(1) : cur_sy_reg + CW'(1);
                end
                else
                begin
                    cc_next = cc_reg + CW'(1);
                    cur_dx_next = col_rev_reg ? cur_dx_reg - CW'(1) : cur_dx_reg + CW'(1);
                    cur_sx_next = col_rev_reg ? cur_sx_reg - CW'(1) : cur_sx_reg + CW'(1);
                end
                if (cc_reg == cx_last_reg && rr_reg == cy_last_reg)
                begin
                    state_next = S_DONE;
                end
                else if (req_reg == fbrop_pkg::REQ_WRITE || req_reg == fbrop_pkg::REQ_FILL)
                begin
                    state_next = S_WR;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_PIXRD:
            begin
                data_next = fr_rdata;
                status_next = 1'b0;
                state_next = S_DONE;
            end
            S_GROW:
            begin
                gl_re = 1'b1;
                cc_next = '0;
                state_next = S_GCOL;
            end
            S_GCOL:
            begin
                fr_we = wrote;
                fr_waddr = pix_addr(px[CW-1:0], py[CW-1:0]);
                fr_wdata = gbit ? color_reg : bg_reg;
                any_next = any_reg || wrote;
                if (cc_reg == GCOL_LAST)
                begin
                    if (rr_reg == GROW_LAST)
                    begin
                        status_next = !any_next;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rr_next = rr_reg + CW'(1);
                        state_next = S_GROW;
                    end
                end
                else
                begin
                    cc_next = cc_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                done = slot_free;
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        vx_reg <= vx_next;
        vy_reg <= vy_next;
        vcx_reg <= vcx_next;
        vcy_reg <= vcy_next;
        vsx_reg <= vsx_next;
        vsy_reg <= vsy_next;
        color_reg <= color_next;
        bg_reg <= bg_next;
        bg_transp_reg <= bg_transp_next;
        code_reg <= code_next;
        gbits_reg <= gbits_next;
        grow_reg <= grow_next;
        cur_dx_reg <= cur_dx_next;
        cur_dy_reg <= cur_dy_next;
        cur_sx_reg <= cur_sx_next;
        cur_sy_reg <= cur_sy_next;
        dx_start_reg <= dx_start_next;
        sx_start_reg <= sx_start_next;
        cc_reg <= cc_next;
        rr_reg <= rr_next;
        cx_last_reg <= cx_last_next;
        cy_last_reg <= cy_last_next;
        col_rev_reg <= col_rev_next;
        row_rev_reg <= row_rev_next;
        any_reg <= any_next;
        data_reg <= data_next;
        status_reg <= status_next;
    end

    fbrop_ram #(
        .WIDTH (fbrop_pkg::PIX_W),
        .DEPTH (FR_DEPTH)
    ) u_frame (
        .clk   (clk),
        .we    (fr_we),
        .waddr (fr_waddr),
        .wdata (fr_wdata),
        .re    (fr_re),
        .raddr (fr_raddr),
        .rdata (fr_rdata)
    );

    fbrop_ram #(
        .WIDTH (8),
        .DEPTH (GL_DEPTH)
    ) u_glyph (
        .clk   (clk),
        .we    (gl_we),
        .waddr (gl_waddr),
        .wdata (gl_wdata),
        .re    (gl_re),
        .raddr (gl_raddr),
        .rdata (gl_rdata)
    );

    `FROE_ASSERT(a_idle_no_write, (state_reg == S_IDLE) |-> (!fr_we && !gl_we), "write while idle")
    `FROE_ASSERT_NEXT(a_start_decode, start, state_reg == S_DECODE, "start did not decode")
    `FROE_ASSERT(a_walk_in_range, (state_reg == S_WR) |-> (cur_dx_reg < cw && cur_dy_reg < ch), "pixel walk left the screen")
    `FROE_ASSERT(a_done_slot, done |-> (slot_free && state_reg == S_DONE), "result without free slot")
endmodule
`default_nettype wire

### hw/rtl/framebuffer_raster_op_engine.sv
// The engine takes one request at a time, bound by the single read and write port of the
// framebuffer. After reset a clearing pass zeroes both stores; in_stall stays high during
// it. Configuration resets to disabled, 64 by 64.
`default_nettype none
module framebuffer_raster_op_engine #(
    parameter int MAX_WIDTH = fbrop_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = fbrop_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [6:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  req_type,
    input  wire logic [15:0] x,
    input  wire logic [15:0] y,
    input  wire logic [15:0] width,
    input  wire logic [15:0] height,
    input  wire logic [15:0] src_x,
    input  wire logic [15:0] src_y,
    input  wire logic [31:0] color,
    input  wire logic [31:0] background,
    input  wire logic [7:0]  char_code,
    input  wire logic [3:0]  glyph_row,
    input  wire logic [7:0]  glyph_bits,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [23:0]      read_data,
    output logic             status
);
    fbrop_pkg::cfg_t cfg_reg, cfg_next;
    logic            out_valid_reg, out_valid_next;
    logic [23:0]     read_data_reg;
    logic            status_reg;
    logic            ready, done, slot_free, start;
    logic [23:0]     res_data;
    logic            res_status;

    assign in_stall = !ready;
    assign start = in_valid && ready;
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign status = status_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                fbrop_pkg::CFG_ENABLE: cfg_next.enable = cfg_data[0];
                fbrop_pkg::CFG_WIDTH:  cfg_next.aw = cfg_data;
                fbrop_pkg::CFG_HEIGHT: cfg_next.ah = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable <= 1'b0;
            cfg_reg.aw <= 7'd64;
            cfg_reg.ah <= 7'd64;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            read_data_reg <= res_data;
            status_reg <= res_status;
        end
    end

    fbrop_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .start      (start),
        .req_type   (req_type),
        .x          (x),
        .y          (y),
        .width      (width),
        .height     (height),
        .src_x      (src_x),
        .src_y      (src_y),
        .color      (color),
        .background (background),
        .char_code  (char_code),
        .glyph_row  (glyph_row),
        .glyph_bits (glyph_bits),
        .slot_free  (slot_free),
        .ready      (ready),
        .done       (done),
        .res_data   (res_data),
        .res_status (res_status)
    );
endmodule
`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for framebuffer_raster_op_engine: drives random and directed
// raster requests, predicts each result and the framebuffer and glyph contents itself.
// Depends on fbrop_pkg and the framebuffer_raster_op_engine RTL.
`default_nettype none
module testbench;
    localparam int FB_W = 64;
    localparam int FB_H = 64;
    localparam int CYCLE_LIMIT = 10000000;
    localparam logic [2:0] REQ_UNUSED = 3'd7;

    typedef struct packed {
        logic [23:0] read_data;
        logic        status;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  req_type;
    logic [15:0] x, y, width, height, src_x, src_y;
    logic [31:0] color, background;
    logic [7:0]  char_code;
    logic [3:0]  glyph_row;
    logic [7:0]  glyph_bits;
    logic        out_valid;
    logic        out_stall;
    logic [23:0] read_data;
    logic        status;

    logic [23:0] pixels [FB_W*FB_H];
    logic [7:0]  glyphs [fbrop_pkg::GLYPH_COUNT*fbrop_pkg::GLYPH_ROWS];
    logic        en_cfg;
    int          aw_cfg, ah_cfg;
    result_t     pending_results [$];
    int          errors;
    int          cycles;
    int          burst_left;
    int          stall_mode;

    framebuffer_raster_op_engine dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .x(x), .y(y), .width(width), .height(height),
        .src_x(src_x), .src_y(src_y), .color(color), .background(background),
        .char_code(char_code), .glyph_row(glyph_row), .glyph_bits(glyph_bits),
        .out_valid(out_valid), .out_stall(out_stall), .read_data(read_data),
        .status(status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int screen_w();
        return aw_cfg < FB_W ? aw_cfg : FB_W;
    endfunction

    function automatic int screen_h();
        return ah_cfg < FB_H ? ah_cfg : FB_H;
    endfunction

    function automatic bit on_screen(int px, int py);
        return px >= 0 && px < screen_w() && py >= 0 && py < screen_h();
    endfunction

    function automatic bit plot(int px, int py, logic [31:0] c);
        if (!on_screen(px, py))
            return 0;
        pixels[py*FB_W + px] = c[23:0];
        return 1;
    endfunction

    function automatic bit paint_rect(int rx, int ry, int rw, int rh, logic [31:0] c,
                                      bit flip);
        int x0, y0, x1, y1;
        x0 = rx;
        y0 = ry;
        x1 = rx + rw;
        y1 = ry + rh;
        if (rw <= 0 || rh <= 0)
            return 0;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > screen_w()) x1 = screen_w();
        if (y1 > screen_h()) y1 = screen_h();
        if (x0 >= x1 || y0 >= y1)
            return 0;
        for (int j = y0; j < y1; j++)
            for (int i = x0; i < x1; i++)
                pixels[j*FB_W + i] = flip ? ~pixels[j*FB_W + i] : c[23:0];
        return 1;
    endfunction

    function automatic bit copy_rect(int dx, int dy, int cw, int ch, int sx, int sy);
        int sw, sh;
        logic [23:0] snap [FB_W*FB_H];
        sw = screen_w();
        sh = screen_h();
        if (cw <= 0 || ch <= 0) return 0;
        if (dx < 0) begin sx -= dx; cw += dx; dx = 0; end
        if (dy < 0) begin sy -= dy; ch += dy; dy = 0; end
        if (sx < 0) begin dx -= sx; cw += sx; sx = 0; end
        if (sy < 0) begin dy -= sy; ch += sy; sy = 0; end
        if (cw <= 0 || ch <= 0) return 0;
        if (dx >= sw || dy >= sh || sx >= sw || sy >= sh) return 0;
        if (dx + cw > sw) cw = sw - dx;
        if (sx + cw > sw) cw = sw - sx;
        if (dy + ch > sh) ch = sh - dy;
        if (sy + ch > sh) ch = sh - sy;
        if (cw <= 0 || ch <= 0) return 0;
        // Copying from a snapshot gives the same result as an overlap-safe move.
        snap = pixels;
        for (int r = 0; r < ch; r++)
            for (int c = 0; c < cw; c++)
                pixels[(dy+r)*FB_W + dx + c] = snap[(sy+r)*FB_W + sx + c];
        return 1;
    endfunction

    function automatic bit render_char(int cx, int cy, logic [7:0] code, logic [31:0] fg,
                                       logic [31:0] bg);
        int g;
        bit any;
        logic [7:0] bits;
        g = code[7] ? 0 : int'(code);
        any = 0;
        for (int r = 0; r < fbrop_pkg::GLYPH_ROWS; r++)
        begin
            bits = glyphs[g*fbrop_pkg::GLYPH_ROWS + r];
            for (int c = 0; c < fbrop_pkg::GLYPH_COLS; c++)
            begin
                if (bits[7-c])
                    any |= plot(cx + c, cy + r, fg);
                else if (bg[31:24] == 8'd0)
                    any |= plot(cx + c, cy + r, bg);
            end
        end
        return any;
    endfunction

    function automatic result_t raster_outcome(logic [2:0] op, int rx, int ry, int rw,
                                               int rh, int sx, int sy, logic [31:0] fg,
                                               logic [31:0] bg, logic [7:0] code,
                                               logic [3:0] grow, logic [7:0] gbits);
        result_t res;
        bit ok;
        res.read_data = 24'd0;
        ok = 0;
        if (en_cfg)
        begin
            case (op)
                fbrop_pkg::REQ_WRITE:  ok = plot(rx, ry, fg);
                fbrop_pkg::REQ_READ:
                    if (on_screen(rx, ry))
                    begin
                        res.read_data = pixels[ry*FB_W + rx];
                        ok = 1;
                    end
                fbrop_pkg::REQ_FILL:   ok = paint_rect(rx, ry, rw, rh, fg, 0);
                fbrop_pkg::REQ_INVERT: ok = paint_rect(rx, ry, rw, rh, 0, 1);
                fbrop_pkg::REQ_BLIT:   ok = copy_rect(rx, ry, rw, rh, sx, sy);
                fbrop_pkg::REQ_GLOAD:
                    if (code < fbrop_pkg::GLYPH_COUNT)
                    begin
                        glyphs[int'(code)*fbrop_pkg::GLYPH_ROWS + grow] = gbits;
                        ok = 1;
                    end
                fbrop_pkg::REQ_CHAR:   ok = render_char(rx, ry, code, fg, bg);
                default:               ok = 0;
            endcase
        end
        res.status = !ok;
        return res;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("framebuffer_raster_op_engine test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 2);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: read_data=%h status=%b", read_data, status);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (read_data !== want.read_data)
                begin
                    $error("read_data: expected %h, got %h", want.read_data, read_data);
                    errors++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %b, got %b", want.status, status);
                    errors++;
                end
            end
        end
    end

    task automatic send_req(logic [2:0] op, logic [15:0] rx, logic [15:0] ry,
                            logic [15:0] rw, logic [15:0] rh, logic [15:0] sx,
                            logic [15:0] sy, logic [31:0] fg, logic [31:0] bg,
                            logic [7:0] code, logic [3:0] grow, logic [7:0] gbits);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(0, 1) ? $urandom_range(1, 12) : 1;
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= op;
        x <= rx;
        y <= ry;
        width <= rw;
        height <= rh;
        src_x <= sx;
        src_y <= sy;
        color <= fg;
        background <= bg;
        char_code <= code;
        glyph_row <= grow;
        glyph_bits <= gbits;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(raster_outcome(op, $signed(rx), $signed(ry), $signed(rw),
            $signed(rh), $signed(sx), $signed(sy), fg, bg, code, grow, gbits));
        if (burst_left == 0)
            in_valid <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            fbrop_pkg::CFG_ENABLE: en_cfg = val[0];
            fbrop_pkg::CFG_WIDTH:  aw_cfg = val;
            default:               ah_cfg = val;
        endcase
    endtask

    function automatic logic [15:0] coord_near();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 20)) - 10);
            default: return 16'($urandom_range(0, 70));
        endcase
    endfunction

    function automatic logic [15:0] size_near();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 4)) - 2);
            3: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic random_req();
        logic [2:0] op;
        op = ($urandom_range(0, 19) == 0) ? REQ_UNUSED : 3'($urandom_range(0, 6));
        send_req(op, coord_near(), coord_near(), size_near(), size_near(), coord_near(),
            coord_near(), $urandom(), $urandom_range(0, 1) ? $urandom() : $urandom_range(0,
            24'hffffff), $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) :
            8'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    task automatic test_disabled();
        send_req(fbrop_pkg::REQ_WRITE, 1, 1, 0, 0, 0, 0, 32'h123456, 0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_READ, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_GLOAD, 0, 0, 0, 0, 0, 0, 0, 0, 3, 2, 8'hff);
    endtask

    task automatic test_directed();
        write_reg(fbrop_pkg::CFG_ENABLE, 7'd1);
        send_req(fbrop_pkg::REQ_WRITE, 0, 0, 0, 0, 0, 0, 32'hffffffff, 0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_WRITE, 63, 63, 0, 0, 0, 0, 32'h00a5a5a5, 0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_WRITE, 64, 0, 0, 0, 0, 0, 32'h1, 0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_READ, 16'hffff, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_READ, 63, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_FILL, 16'hfffe, 16'hfffe, 5, 4, 0, 0, 32'h00123456,
            0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_FILL, 2, 2, 0, 3, 0, 0, 32'h1, 0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_FILL, 16'h7fff, 0, 16'h7fff, 16'h7fff, 0, 0, 32'h1,
            0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_INVERT, 60, 60, 16'h7fff, 16'h7fff, 0, 0, 0, 0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_BLIT, 1, 1, 4, 4, 0, 0, 0, 0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_BLIT, 0, 0, 4, 4, 1, 1, 0, 0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_BLIT, 16'hfffd, 2, 8, 8, 16'hfffe, 0, 0, 0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_BLIT, 10, 10, 5, 5, 64, 0, 0, 0, 0, 0, 0);
        send_req(fbrop_pkg::REQ_GLOAD, 0, 0, 0, 0, 0, 0, 0, 0, 127, 15, 8'h81);
        send_req(fbrop_pkg::REQ_GLOAD, 0, 0, 0, 0, 0, 0, 0, 0, 128, 0, 8'hff);
        send_req(fbrop_pkg::REQ_GLOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8'hf0);
        send_req(fbrop_pkg::REQ_CHAR, 60, 56, 0, 0, 0, 0, 32'hffffff, 32'h00000055,
            127, 0, 0);
        send_req(fbrop_pkg::REQ_CHAR, 4, 4, 0, 0, 0, 0, 32'h00abcdef, 32'hff000000,
            8'hff, 0, 0);
        send_req(fbrop_pkg::REQ_CHAR, 20, 20, 0, 0, 0, 0, 32'h1, 32'h01000000, 5, 0, 0);
        send_req(REQ_UNUSED, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++)
            random_req();
    endtask

    task automatic test_small_screen();
        write_reg(fbrop_pkg::CFG_WIDTH, 7'd0);
        write_reg(fbrop_pkg::CFG_HEIGHT, 7'd0);
        test_random(10);
        write_reg(fbrop_pkg::CFG_WIDTH, 7'd127);
        write_reg(fbrop_pkg::CFG_HEIGHT, 7'd13);
        test_random(25);
        write_reg(fbrop_pkg::CFG_WIDTH, 7'd20);
        write_reg(fbrop_pkg::CFG_HEIGHT, 7'd64);
        test_random(25);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = fbrop_pkg::CFG_ENABLE;
        cfg_data = 7'd0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        {req_type, x, y, width, height, src_x, src_y} = '0;
        {color, background, char_code, glyph_row, glyph_bits} = '0;
        errors = 0;
        cycles = 0;
        burst_left = 0;
        stall_mode = 0;
        en_cfg = 1'b0;
        aw_cfg = 64;
        ah_cfg = 64;
        foreach (pixels[i]) pixels[i] = '0;
        foreach (glyphs[i]) glyphs[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_disabled();
        test_directed();
        test_random(35);
        drain();
        test_random(20);
        test_small_screen();
        write_reg(fbrop_pkg::CFG_WIDTH, 7'd64);
        write_reg(fbrop_pkg::CFG_HEIGHT, 7'd64);
        write_reg(fbrop_pkg::CFG_ENABLE, 7'd0);
        test_random(5);
        drain();
        repeat (200) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("framebuffer_raster_op_engine test passed");
        else
            $display("framebuffer_raster_op_engine test failed");
        $finish;
    end
endmodule
`default_nettype wire
